>>> rtl/qau_pkg.sv
// Shared constants, command codes and pipeline side-band types for the quaternion unit.
package qau_pkg;

  // Fixed point format of all components
  localparam int FRAC_BITS   = 28;
  // Newton iterations of the inverse square root
  localparam int RSQRT_STEPS = 4;

  localparam int CW = 32;   // component width
  localparam int MW = 62;   // normalized sum of squares, value in [2^60, 2^62)
  localparam int YW = 32;   // inverse square root estimate, Q2.30
  localparam int XW = 34;   // x*y*y term of one Newton step
  localparam int EW = 6;    // half of the normalizing shift, -30..2

  localparam logic [YW-1:0] Y0_LOW  = 32'h3666_6666;  // 0.85, start for m below 2^61
  localparam logic [YW-1:0] Y0_HIGH = 32'h2666_6666;  // 0.6, start for m from 2^61
  localparam logic [XW-1:0] THREE   = XW'(3) << 30;   // 3.0 in Q2.30

  typedef enum logic [1:0] {
    CMD_PRODUCT   = 2'd0,
    CMD_ROTATE    = 2'd1,
    CMD_NORMALIZE = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef logic [3:0][CW-1:0] quat_t;

  // Everything that rides along the inverse square root pipeline
  typedef struct packed {
    logic                 vld;
    cmd_t                 cmd;
    quat_t                c;     // operand a, scaled at the end of normalize
    logic signed [EW-1:0] e;     // half of the normalizing shift
    logic                 zero;  // sum of squares was zero
    quat_t                qr;    // finished product or rotate word
    logic                 qsat;  // its saturation flag
  } side_t;

endpackage

>>> rtl/quaternion_arithmetic_unit.sv
// Quaternion product, vector rotation and normalization in one stallable pipeline.
// Throughput: one word per cycle while the output is not stalled; every command runs the same
// fixed-depth pipeline, whose length is set by the Newton stages of the inverse square root.
// A stalled output freezes the whole pipeline; in_ready is high while out_ready is high or out_valid is low.
// Reset (synchronous, active high) clears all valid bits; data registers keep junk.
module quaternion_arithmetic_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] a_w,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] b_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] r_x,
  output logic signed [31:0] r_y,
  output logic signed [31:0] r_z,
  output logic signed [31:0] r_w,
  output logic               saturated
);

  localparam int CW  = qau_pkg::CW;
  localparam int FB  = qau_pkg::FRAC_BITS;
  localparam int PW  = 2*CW;      // product width
  localparam int SW  = PW + 2;    // sum of four products
  localparam int QW  = PW + 1;    // scaled normalize product
  localparam int NW  = PW + 1;    // exact sum of squares
  localparam int CH  = 13;        // leading-one search chunk
  localparam int NCH = 5;         // chunks over the sum of squares
  localparam int MW  = qau_pkg::MW;
  localparam int YW  = qau_pkg::YW;
  localparam int EW  = qau_pkg::EW;

  localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (FB-1));
  localparam logic signed [SW-1:0] MAXV = {{(SW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic [CW-1:0] v;
    logic          sat;
  } rc_t;

  function automatic rc_t clamp32(input logic signed [SW-1:0] v);
    rc_t r;
    r.sat = 1'b0;
    r.v   = v[CW-1:0];
    if (v > MAXV) begin
      r.sat = 1'b1;
      r.v   = MAXV[CW-1:0];
    end else if (v < MINV) begin
      r.sat = 1'b1;
      r.v   = MINV[CW-1:0];
    end
    return r;
  endfunction

  function automatic rc_t round_clamp(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = (s + HALF) >>> FB;
    return clamp32(t);
  endfunction

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: capture word, copy a into b for normalize
  logic                v_s1;
  qau_pkg::cmd_t       cmd_s1;
  qau_pkg::quat_t      a_s1, b_s1;

  always_ff @(posedge clk) begin
    if (rst) v_s1 <= 1'b0;
    else if (adv) v_s1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s1 <= qau_pkg::cmd_t'(command);
      a_s1   <= {a_w, a_z, a_y, a_x};
      if (command == qau_pkg::CMD_NORMALIZE) b_s1 <= {a_w, a_z, a_y, a_x};
      else b_s1 <= {b_w, b_z, b_y, b_x};
    end
  end

  // ---------------- stage 2: all sixteen component products
  logic                v_s2;
  qau_pkg::cmd_t       cmd_s2;
  qau_pkg::quat_t      a_s2;
  logic signed [PW-1:0] p_s2 [4][4];

  always_ff @(posedge clk) begin
    if (rst) v_s2 <= 1'b0;
    else if (adv) v_s2 <= v_s1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s2 <= cmd_s1;
      a_s2   <= a_s1;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          p_s2[i][j] <= $signed(a_s1[i]) * $signed(b_s1[j]);
    end
  end

  // ---------------- stage 3: exact sums, sum of squares
  logic signed [SW-1:0] pe [4][4];
  logic signed [SW-1:0] pw [4];
  logic                 v_s3;
  qau_pkg::cmd_t        cmd_s3;
  qau_pkg::quat_t       a_s3;
  logic signed [SW-1:0] sum_s3 [4];
  logic [NW-1:0]        s_s3;

  // Drop the b_w terms for the first half of a rotation
  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        pe[i][j] = SW'(p_s2[i][j]);
    for (int i = 0; i < 4; i++)
      pw[i] = (cmd_s2 == qau_pkg::CMD_ROTATE) ? '0 : pe[i][3];
  end

  always_ff @(posedge clk) begin
    if (rst) v_s3 <= 1'b0;
    else if (adv) v_s3 <= v_s2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s3    <= cmd_s2;
      a_s3      <= a_s2;
      sum_s3[0] <= pe[3][0] + pw[0] + pe[1][2] - pe[2][1];
      sum_s3[1] <= pe[3][1] + pw[1] + pe[2][0] - pe[0][2];
      sum_s3[2] <= pe[3][2] + pw[2] + pe[0][1] - pe[1][0];
      sum_s3[3] <= pw[3] - pe[0][0] - pe[1][1] - pe[2][2];
      s_s3      <= NW'(p_s2[0][0]) + NW'(p_s2[1][1]) + NW'(p_s2[2][2]) + NW'(p_s2[3][3]);
    end
  end

  // ---------------- stage 4: round and clamp, leading-one per chunk
  rc_t                  rc4 [4];
  logic                 nz4_next [NCH];
  logic [3:0]           pos4_next [NCH];
  logic                 v_s4;
  qau_pkg::cmd_t        cmd_s4;
  qau_pkg::quat_t       a_s4, q_s4;
  logic                 sat_s4;
  logic [NW-1:0]        s_s4;
  logic                 nz_s4 [NCH];
  logic [3:0]           pos_s4 [NCH];

  always_comb begin
    for (int k = 0; k < 4; k++) rc4[k] = round_clamp(sum_s3[k]);
    for (int k = 0; k < NCH; k++) begin
      nz4_next[k]  = |s_s3[k*CH +: CH];
      pos4_next[k] = '0;
      for (int b = 0; b < CH; b++)
        if (s_s3[k*CH + b]) pos4_next[k] = 4'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v_s4 <= 1'b0;
    else if (adv) v_s4 <= v_s3;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s4 <= cmd_s3;
      a_s4   <= a_s3;
      s_s4   <= s_s3;
      for (int k = 0; k < 4; k++) q_s4[k] <= rc4[k].v;
      sat_s4 <= rc4[0].sat | rc4[1].sat | rc4[2].sat | rc4[3].sat;
      for (int k = 0; k < NCH; k++) begin
        nz_s4[k]  <= nz4_next[k];
        pos_s4[k] <= pos4_next[k];
      end
    end
  end

  // ---------------- stage 5: second rotation products, bit length
  logic [6:0]           bl5_next;
  logic                 v_s5;
  qau_pkg::cmd_t        cmd_s5;
  qau_pkg::quat_t       a_s5, q_s5;
  logic                 sat_s5;
  logic [NW-1:0]        s_s5;
  logic [6:0]           bl_s5;
  logic signed [PW-1:0] m_s5 [4][4];

  always_comb begin
    bl5_next = '0;
    for (int k = 0; k < NCH; k++)
      if (nz_s4[k]) bl5_next = 7'(CH*k) + 7'(pos_s4[k]) + 7'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) v_s5 <= 1'b0;
    else if (adv) v_s5 <= v_s4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s5 <= cmd_s4;
      a_s5   <= a_s4;
      q_s5   <= q_s4;
      sat_s5 <= sat_s4;
      s_s5   <= s_s4;
      bl_s5  <= bl5_next;
      for (int k = 0; k < 4; k++)
        for (int j = 0; j < 4; j++)
          if (k != j) m_s5[k][j] <= $signed(q_s4[k]) * $signed(a_s4[j]);
          else m_s5[k][j] <= '0;
    end
  end

  // ---------------- stage 6: rotation sums, even normalizing shift
  logic signed [SW-1:0] me [4][4];
  logic signed [7:0]    sh6_next;
  logic                 v_s6;
  qau_pkg::cmd_t        cmd_s6;
  qau_pkg::quat_t       a_s6, q_s6;
  logic                 sat_s6;
  logic [NW-1:0]        s_s6;
  logic signed [SW-1:0] rs_s6 [3];
  logic signed [7:0]    sh_s6;
  logic signed [EW-1:0] e_s6;
  logic                 zero_s6;

  always_comb begin
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 4; j++)
        me[k][j] = SW'(m_s5[k][j]);
    sh6_next = $signed({1'b0, bl_s5}) - 8'sd62;
    if (sh6_next[0]) sh6_next = sh6_next + 8'sd1;
  end

  always_ff @(posedge clk) begin
    if (rst) v_s6 <= 1'b0;
    else if (adv) v_s6 <= v_s5;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_s6   <= cmd_s5;
      a_s6     <= a_s5;
      q_s6     <= q_s5;
      sat_s6   <= sat_s5;
      s_s6     <= s_s5;
      rs_s6[0] <= me[0][3] - me[3][0] - me[1][2] + me[2][1];
      rs_s6[1] <= me[1][3] - me[3][1] - me[2][0] + me[0][2];
      rs_s6[2] <= me[2][3] - me[3][2] - me[0][1] + me[1][0];
      sh_s6    <= sh6_next;
      e_s6     <= EW'(sh6_next >>> 1);
      zero_s6  <= (bl_s5 == 7'd0);
    end
  end

  // ---------------- stage 7: finish product/rotate, normalize mantissa
  rc_t                  rc7 [3];
  logic [7:0]           nsh7;
  logic [NW-1:0]        mf7;
  qau_pkg::side_t       side7_next;
  qau_pkg::side_t       side_s7;
  logic [MW-1:0]        m_s7;
  logic [YW-1:0]        y0_s7;

  always_comb begin
    for (int k = 0; k < 3; k++) rc7[k] = round_clamp(rs_s6[k]);
    nsh7 = -sh_s6;
    if (sh_s6[7]) mf7 = s_s6 << nsh7[5:0];
    else mf7 = s_s6 >> sh_s6[2:0];
    side7_next.vld  = v_s6;
    side7_next.cmd  = cmd_s6;
    side7_next.c    = a_s6;
    side7_next.e    = e_s6;
    side7_next.zero = zero_s6;
    if (cmd_s6 == qau_pkg::CMD_ROTATE) begin
      side7_next.qr   = {{CW{1'b0}}, rc7[2].v, rc7[1].v, rc7[0].v};
      side7_next.qsat = sat_s6 | rc7[0].sat | rc7[1].sat | rc7[2].sat;
    end else begin
      side7_next.qr   = q_s6;
      side7_next.qsat = sat_s6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) side_s7.vld <= 1'b0;
    else if (adv) begin
      side_s7 <= side7_next;
      m_s7    <= mf7[MW-1:0];
      y0_s7   <= mf7[MW-1] ? qau_pkg::Y0_HIGH : qau_pkg::Y0_LOW;
    end
  end

  // ---------------- inverse square root
  qau_pkg::side_t side_r;
  logic [YW-1:0]  y_r;

  qau_rsqrt u_rsqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .side_in  (side_s7),
    .m_in     (m_s7),
    .y_in     (y0_s7),
    .side_out (side_r),
    .y_out    (y_r)
  );

  // ---------------- F1: scale a by the estimate
  logic signed [7:0]    qf1_next;
  qau_pkg::side_t       side_f1;
  logic signed [QW-1:0] pn_f1 [4];
  logic [5:0]           q_f1;

  assign qf1_next = 8'(60 - FB) + 8'(side_r.e);

  always_ff @(posedge clk) begin
    if (rst) side_f1.vld <= 1'b0;
    else if (adv) begin
      side_f1 <= side_r;
      q_f1    <= qf1_next[5:0];
      for (int k = 0; k < 4; k++)
        pn_f1[k] <= $signed(side_r.c[k]) * $signed({1'b0, y_r});
    end
  end

  // ---------------- F2: round half up at the variable shift
  qau_pkg::side_t       side_f2;
  logic signed [QW-1:0] rn_f2 [4];

  always_ff @(posedge clk) begin
    if (rst) side_f2.vld <= 1'b0;
    else if (adv) begin
      side_f2 <= side_f1;
      for (int k = 0; k < 4; k++)
        if (q_f1 == 6'd0) rn_f2[k] <= pn_f1[k];
        else rn_f2[k] <= (pn_f1[k] + (QW'(1) <<< (q_f1 - 6'd1))) >>> q_f1;
    end
  end

  // ---------------- F3: select by command into the output register
  rc_t            rcn [4];
  qau_pkg::quat_t rq_next, rq;
  logic           sat_next, sat_q;

  always_comb begin
    for (int k = 0; k < 4; k++) rcn[k] = clamp32(SW'(rn_f2[k]));
    rq_next  = '0;
    sat_next = 1'b0;
    unique case (side_f2.cmd) inside
      qau_pkg::CMD_PRODUCT, qau_pkg::CMD_ROTATE: begin
        rq_next  = side_f2.qr;
        sat_next = side_f2.qsat;
      end
      qau_pkg::CMD_NORMALIZE: begin
        if (side_f2.zero) begin
          rq_next[3] = CW'(64'd1 << FB);
        end else begin
          for (int k = 0; k < 4; k++) rq_next[k] = rcn[k].v;
          sat_next = rcn[0].sat | rcn[1].sat | rcn[2].sat | rcn[3].sat;
        end
      end
      default: begin
        rq_next  = '0;
        sat_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= side_f2.vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rq    <= rq_next;
      sat_q <= sat_next;
    end
  end

  assign r_x       = rq[0];
  assign r_y       = rq[1];
  assign r_z       = rq[2];
  assign r_w       = rq[3];
  assign saturated = sat_q;

  // ---------------- assertions
  // An accepted word enters the first stage
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(in_valid && in_ready)) |-> v_s1)
    else $error("accepted word missing from first stage");

  // A stall freezes the valid bits along the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> (v_s1 == $past(v_s1)) && (side_s7.vld == $past(side_s7.vld))
             && (side_f2.vld == $past(side_f2.vld)))
    else $error("pipeline moved during stall");

  // The inverse square root estimate stays below 2.0
  a_rsqrt: assert property (@(posedge clk) disable iff (rst)
    (side_r.vld && side_r.cmd == qau_pkg::CMD_NORMALIZE && !side_r.zero) |-> !y_r[YW-1])
    else $error("inverse square root estimate out of range");

endmodule

>>> rtl/qau_rsqrt.sv
// Pipelined Newton iteration for the inverse square root, three stages per step.
module qau_rsqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  qau_pkg::side_t            side_in,
  input  logic [qau_pkg::MW-1:0]    m_in,
  input  logic [qau_pkg::YW-1:0]    y_in,
  output qau_pkg::side_t            side_out,
  output logic [qau_pkg::YW-1:0]    y_out
);

  localparam int N  = qau_pkg::RSQRT_STEPS;
  localparam int MW = qau_pkg::MW;
  localparam int YW = qau_pkg::YW;
  localparam int XW = qau_pkg::XW;

  // Stage registers: a = y squared, b = x*y*y, c = new estimate
  qau_pkg::side_t   sd_a [N];
  qau_pkg::side_t   sd_b [N];
  qau_pkg::side_t   sd_c [N];
  logic [MW-1:0]    m_a  [N];
  logic [MW-1:0]    m_b  [N];
  logic [MW-1:0]    m_c  [N];
  logic [YW-1:0]    y_a  [N];
  logic [YW-1:0]    y_b  [N];
  logic [YW-1:0]    y_c  [N];
  logic [YW-1:0]    y2_a [N];
  logic [XW-1:0]    xy2_b [N];

  // Step inputs and per-step arithmetic
  qau_pkg::side_t   sd_i [N];
  logic [MW-1:0]    m_i  [N];
  logic [YW-1:0]    y_i  [N];
  logic [2*YW-1:0]  yy   [N];
  logic [2*YW-1:0]  mxy  [N];
  logic [YW-1:0]    h    [N];
  logic [2*YW-1:0]  yh   [N];

  // Chain the steps
  always_comb begin
    sd_i[0] = side_in;
    m_i[0]  = m_in;
    y_i[0]  = y_in;
    for (int s = 1; s < N; s++) begin
      sd_i[s] = sd_c[s-1];
      m_i[s]  = m_c[s-1];
      y_i[s]  = y_c[s-1];
    end
  end

  // One multiplier per stage: y*y, then x*y2, then y*h
  always_comb begin
    for (int s = 0; s < N; s++) begin
      yy[s]  = y_i[s] * y_i[s];
      mxy[s] = {{(2*YW-(MW-30)){1'b0}}, m_a[s][MW-1:30]} * {{YW{1'b0}}, y2_a[s]};
      h[s]   = (xy2_b[s] > qau_pkg::THREE) ? '0 : YW'(qau_pkg::THREE - xy2_b[s]);
      yh[s]  = y_b[s] * h[s];
    end
  end

  // Advance all steps together; only valid bits reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N; s++) begin
        sd_a[s].vld <= 1'b0;
        sd_b[s].vld <= 1'b0;
        sd_c[s].vld <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < N; s++) begin
        sd_a[s]  <= sd_i[s];
        m_a[s]   <= m_i[s];
        y_a[s]   <= y_i[s];
        y2_a[s]  <= yy[s][YW+29:30];
        sd_b[s]  <= sd_a[s];
        m_b[s]   <= m_a[s];
        y_b[s]   <= y_a[s];
        xy2_b[s] <= mxy[s][XW+29:30];
        sd_c[s]  <= sd_b[s];
        m_c[s]   <= m_b[s];
        y_c[s]   <= yh[s][YW+30:31];
      end
    end
  end

  assign side_out = sd_c[N-1];
  assign y_out    = y_c[N-1];

endmodule

>>> test/qau_checker.sv
// Checker for the quaternion unit: watches both channels, predicts each result word and compares.
module qau_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  input  logic signed [31:0] a_w,
  input  logic signed [31:0] b_x,
  input  logic signed [31:0] b_y,
  input  logic signed [31:0] b_z,
  input  logic signed [31:0] b_w,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] r_x,
  input  logic signed [31:0] r_y,
  input  logic signed [31:0] r_z,
  input  logic signed [31:0] r_w,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending,
  output logic               accepted_any
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    logic               sat;
  } quat_word_t;

  quat_word_t result_queue[$];

  // Round a sum of double-width products half up to FRAC_BITS, exact in 80 bits
  function automatic logic signed [79:0] round_sum(logic signed [79:0] s);
    logic signed [79:0] t;
    t = s + (80'sd1 <<< (qau_pkg::FRAC_BITS - 1));
    return t >>> qau_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clamp(logic signed [79:0] v, ref logic sat);
    if (v > 80'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -80'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic quat_word_t predict_word(qau_pkg::cmd_t cmd, logic signed [79:0] ax,
      logic signed [79:0] ay, logic signed [79:0] az, logic signed [79:0] aw,
      logic signed [79:0] bx, logic signed [79:0] by, logic signed [79:0] bz,
      logic signed [79:0] bw);
    logic signed [79:0] r[4];
    logic signed [79:0] ix, iy, iz, iw, p;
    logic [79:0] sum_sq, m, y, y2, xy2, h;
    logic sat;
    int bits, sh, q;
    quat_word_t res;
    logic signed [79:0] c[4];
    sat = 1'b0;
    r = '{default: 0};
    c[0] = ax; c[1] = ay; c[2] = az; c[3] = aw;
    case (cmd)
      qau_pkg::CMD_PRODUCT: begin
        r[0] = round_sum(aw*bx + bw*ax + ay*bz - az*by);
        r[1] = round_sum(aw*by + bw*ay + az*bx - ax*bz);
        r[2] = round_sum(aw*bz + bw*az + ax*by - ay*bx);
        r[3] = round_sum(aw*bw - ax*bx - ay*by - az*bz);
      end
      qau_pkg::CMD_ROTATE: begin
        // clamp the first product before the conjugate product
        ix = clamp(round_sum(aw*bx + ay*bz - az*by), sat);
        iy = clamp(round_sum(aw*by + az*bx - ax*bz), sat);
        iz = clamp(round_sum(aw*bz + ax*by - ay*bx), sat);
        iw = clamp(round_sum(-ax*bx - ay*by - az*bz), sat);
        r[0] = round_sum(ix*aw - iw*ax - iy*az + iz*ay);
        r[1] = round_sum(iy*aw - iw*ay - iz*ax + ix*az);
        r[2] = round_sum(iz*aw - iw*az - ix*ay + iy*ax);
      end
      qau_pkg::CMD_NORMALIZE: begin
        sum_sq = ax*ax + ay*ay + az*az + aw*aw;
        if (sum_sq == 0) begin
          r[3] = 80'sd1 <<< qau_pkg::FRAC_BITS;
        end else begin
          // a sum that overflows 64 bits pins the mantissa at 2^60
          if (sum_sq[79:64] != 0) begin
            sh = 4;
            m = 80'd1 << 60;
          end else begin
            bits = 0;
            for (int k = 0; k < 64; k++) if (sum_sq[k]) bits = k + 1;
            sh = bits - 62;
            if (sh % 2 != 0) sh += 1;
            m = (sh >= 0) ? (sum_sq >> sh) : (sum_sq << (-sh));
          end
          y = (m < (80'd1 << 61)) ? 80'h36666666 : 80'h26666666;
          for (int k = 0; k < qau_pkg::RSQRT_STEPS; k++) begin
            y2 = (y * y) >> 30;
            xy2 = ((m >> 30) * y2) >> 30;
            h = (xy2 > (80'd3 << 30)) ? 0 : (80'd3 << 30) - xy2;
            y = (y * h) >> 31;
          end
          q = 60 + sh / 2 - qau_pkg::FRAC_BITS;
          for (int k = 0; k < 4; k++) begin
            p = c[k] * $signed(y);
            if (q > 0) p = (p + (80'sd1 <<< (q - 1))) >>> q;
            r[k] = p;
          end
        end
      end
      default: ;
    endcase
    res.x = clamp(r[0], sat);
    res.y = clamp(r[1], sat);
    res.z = clamp(r[2], sat);
    res.w = clamp(r[3], sat);
    res.sat = sat;
    return res;
  endfunction

  // Queue a prediction per accepted word, compare each delivered word
  always @(posedge clk) begin
    quat_word_t want;
    accepted_any <= !rst && ((in_valid && in_ready) || (out_valid && out_ready));
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        result_queue.push_back(predict_word(qau_pkg::cmd_t'(command), a_x, a_y, a_z, a_w,
                                            b_x, b_y, b_z, b_w));
      end
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = result_queue.pop_front();
          if (want.x !== r_x || want.y !== r_y || want.z !== r_z || want.w !== r_w ||
              want.sat !== saturated) begin
            if (fail_count < 10)
              $display("mismatch: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                       want.x, want.y, want.z, want.w, want.sat,
                       r_x, r_y, r_z, r_w, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = result_queue.size();
endmodule

>>> test/tb_quaternion_arithmetic_unit.sv
// Testbench top for the quaternion unit: stimulus, idling, watchdog and verdict.
module tb_quaternion_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 400;
  localparam int IDLE_LIMIT = 400;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready, saturated;
  logic [1:0] command;
  logic signed [31:0] a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, r_x, r_y, r_z, r_w;
  int fail_count, pending, idle_cycles;
  logic accepted_any;

  quaternion_arithmetic_unit dut (.*);
  qau_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Pick a component: extremes, zero, unit values, random within one unit, small or full-range random
  function automatic logic signed [31:0] pick_comp();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return 32'sh10000000;
      4: return -32'sh10000000;
      5, 6: return $signed($urandom_range(0, 32'h20000000)) - 32'sh10000000;
      7: return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom;
    endcase
  endfunction

  // Drive one word from a falling edge; valid stays up when no idle cycles are drawn
  task automatic send_word(qau_pkg::cmd_t cmd, logic signed [31:0] ax,
      logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] aw,
      logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz,
      logic signed [31:0] bw);
    int n;
    n = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    command <= cmd;
    a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
    b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Output side: a random stall with out_ready low before each word is taken
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      n = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || accepted_any) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] big, neg;
    rst = 1'b1; in_valid = 1'b0; command = '0;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    big = 32'sh7fffffff;
    neg = 32'sh80000000;
    // Directed: every command, extremes, zero normalize, unused command
    send_word(qau_pkg::CMD_PRODUCT, 0, 0, 0, 32'sh10000000, 0, 0, 0, 32'sh10000000);
    send_word(qau_pkg::CMD_PRODUCT, big, big, big, big, big, big, big, big);
    send_word(qau_pkg::CMD_PRODUCT, neg, neg, neg, neg, big, neg, big, neg);
    send_word(qau_pkg::CMD_PRODUCT, neg, big, neg, big, neg, neg, neg, neg);
    send_word(qau_pkg::CMD_ROTATE, 0, 0, 0, 32'sh10000000, 32'sh10000000, -1, 5, big);
    send_word(qau_pkg::CMD_ROTATE, big, neg, big, neg, big, big, neg, 0);
    send_word(qau_pkg::CMD_ROTATE, 32'sh0b504f33, 0, 0, 32'sh0b504f33, 0, 32'sh10000000,
              0, 0);
    send_word(qau_pkg::CMD_NORMALIZE, 0, 0, 0, 0, 1, 2, 3, 4);
    send_word(qau_pkg::CMD_NORMALIZE, neg, neg, neg, neg, 0, 0, 0, 0);
    send_word(qau_pkg::CMD_NORMALIZE, big, big, big, big, 0, 0, 0, 0);
    send_word(qau_pkg::CMD_NORMALIZE, 1, 0, 0, 0, 0, 0, 0, 0);
    send_word(qau_pkg::CMD_NORMALIZE, 0, -1, 1, 0, 0, 0, 0, 0);
    send_word(qau_pkg::CMD_NORMALIZE, 32'sh10000000, 0, 0, 0, 0, 0, 0, 0);
    send_word(qau_pkg::CMD_NORMALIZE, 3, 5, 7, 11, 0, 0, 0, 0);
    send_word(qau_pkg::CMD_NONE, big, neg, big, neg, -1, -1, -1, -1);
    for (int i = 0; i < NUM_RANDOM; i++)
      send_word(qau_pkg::cmd_t'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2)),
                pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                pick_comp(), pick_comp(), pick_comp(), pick_comp());
    // Drop valid after the last word
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
